### hdl/flsm_pkg.sv
// ----------------------------------------------------------------------------
// flsm_pkg
// Shared types, codes and saturating helpers for the frame loss monitor.
// ----------------------------------------------------------------------------
package flsm_pkg;

   localparam int TS_WIDTH  = 48;
   localparam int CNT_WIDTH = 32;
   localparam int PEND_WIDTH = 16;
   localparam int THR_WIDTH = 8;
   localparam int APB_DATA_WIDTH = 32;
   localparam int APB_ADDR_WIDTH = 3;

   localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_VSYNC = 2'd2,
      KIND_SWAP  = 2'd3
   } flsm_kind_type;

   // register index decoded from the byte address
   typedef enum logic [0:0] {
      REG_LOSS_RUN_THRESHOLD = 1'b0
   } flsm_reg_type;

   typedef struct packed {
      logic [TS_WIDTH-1:0]  start_time;
      logic [CNT_WIDTH-1:0] duration;
      logic [CNT_WIDTH-1:0] total_frames;
      logic [CNT_WIDTH-1:0] missed_frames;
      logic [CNT_WIDTH-1:0] max_frame_time;
      logic [CNT_WIDTH-1:0] max_missed_run;
   } flsm_result_type;

   function automatic logic [CNT_WIDTH-1:0] sat_inc32(input logic [CNT_WIDTH-1:0] v);
      logic [CNT_WIDTH-1:0] r;
      r = (v == '1) ? v : v + CNT_WIDTH'(1);
      return r;
   endfunction

   function automatic logic [CNT_WIDTH-1:0] sat_diff32(input logic [TS_WIDTH-1:0] later,
                                                       input logic [TS_WIDTH-1:0] earlier);
      logic [TS_WIDTH-1:0]  d;
      logic [CNT_WIDTH-1:0] r;
      d = later - earlier;
      if (later <= earlier) begin
         r = '0;
      end else if (d[TS_WIDTH-1:CNT_WIDTH] != '0) begin
         r = '1;
      end else begin
         r = d[CNT_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

### hdl/flsm_if.sv
// ----------------------------------------------------------------------------
// flsm_req_if / flsm_rsp_if
// Valid/ready channels for event items and report items.
// ----------------------------------------------------------------------------
interface flsm_req_if
   import flsm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [TS_WIDTH-1:0] timestamp_ms;

   modport source (output valid, kind, timestamp_ms, input ready);
   modport sink   (input valid, kind, timestamp_ms, output ready);
endinterface

interface flsm_rsp_if
   import flsm_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [TS_WIDTH-1:0]  start_time;
   logic [CNT_WIDTH-1:0] duration;
   logic [CNT_WIDTH-1:0] total_frames;
   logic [CNT_WIDTH-1:0] missed_frames;
   logic [CNT_WIDTH-1:0] max_frame_time;
   logic [CNT_WIDTH-1:0] max_missed_run;

   modport source (output valid, start_time, duration, total_frames, missed_frames,
                   max_frame_time, max_missed_run, input ready);
   modport sink   (input valid, start_time, duration, total_frames, missed_frames,
                   max_frame_time, max_missed_run, output ready);
endinterface

### hdl/flsm_csr.sv
// ----------------------------------------------------------------------------
// flsm_csr
// APB register file holding the loss run threshold.
// ----------------------------------------------------------------------------
module flsm_csr
   import flsm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [APB_ADDR_WIDTH-1:0] paddr,
   input  logic [APB_DATA_WIDTH-1:0] pwdata,
   output logic [APB_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic [THR_WIDTH-1:0]      threshold
);

   logic [THR_WIDTH-1:0] thr_ff;
   logic [THR_WIDTH-1:0] thr_in;
   flsm_reg_type         reg_sel;

   assign reg_sel = flsm_reg_type'(paddr[APB_ADDR_WIDTH-1]);
   assign pready  = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && pready) begin
         case (reg_sel)
            REG_LOSS_RUN_THRESHOLD: thr_in = pwdata[THR_WIDTH-1:0];
            default: thr_in = thr_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LOSS_RUN_THRESHOLD: prdata = APB_DATA_WIDTH'(thr_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign threshold = thr_ff;

endmodule

### hdl/flsm_core.sv
// ----------------------------------------------------------------------------
// flsm_core
// Event input register and the monitor state update.
// ----------------------------------------------------------------------------
module flsm_core
   import flsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [THR_WIDTH-1:0] threshold,
   flsm_req_if.sink             req,
   output logic                 res_valid,
   input  logic                 res_ready,
   output flsm_result_type      result
);

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   flsm_kind_type        s1_kind_ff, s1_kind_in;
   logic [TS_WIDTH-1:0]  s1_ts_ff, s1_ts_in;

   // monitor state
   logic                  mon_ff, mon_in;
   logic                  first_ff, first_in;
   logic [TS_WIDTH-1:0]   start_ff, start_in;
   logic [CNT_WIDTH-1:0]  frame_ff, frame_in;
   logic [CNT_WIDTH-1:0]  miss_ff, miss_in;
   logic [CNT_WIDTH-1:0]  run_ff, run_in;
   logic [CNT_WIDTH-1:0]  longest_run_ff, longest_run_in;
   logic [CNT_WIDTH-1:0]  hit_ff, hit_in;
   logic                  have_prev_ff, have_prev_in;
   logic [TS_WIDTH-1:0]   prev_ts_ff, prev_ts_in;
   logic [CNT_WIDTH-1:0]  longest_iv_ff, longest_iv_in;
   logic [PEND_WIDTH-1:0] pend_ff, pend_in;

   logic                 advance;
   logic [CNT_WIDTH-1:0] thr_wide;

   assign thr_wide  = CNT_WIDTH'(threshold);
   assign res_valid = s1_valid_ff && (s1_kind_ff == KIND_STOP) && mon_ff && (miss_ff != '0);
   assign advance   = !res_valid || res_ready;
   assign req.ready = advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_ts_in    = s1_ts_ff;
      if (advance) begin
         s1_valid_in = req.valid;
         s1_kind_in  = flsm_kind_type'(req.kind);
         s1_ts_in    = req.timestamp_ms;
      end
   end

   always_comb begin
      result.start_time     = start_ff;
      result.duration       = sat_diff32(s1_ts_ff, start_ff);
      result.total_frames   = frame_ff;
      result.missed_frames  = miss_ff;
      result.max_frame_time = longest_iv_ff;
      result.max_missed_run = longest_run_ff;
   end

   always_comb begin
      logic [CNT_WIDTH-1:0] run_v;
      logic [CNT_WIDTH-1:0] hit_v;
      logic [CNT_WIDTH-1:0] iv;
      mon_in         = mon_ff;
      first_in       = first_ff;
      start_in       = start_ff;
      frame_in       = frame_ff;
      miss_in        = miss_ff;
      run_in         = run_ff;
      longest_run_in = longest_run_ff;
      hit_in         = hit_ff;
      have_prev_in   = have_prev_ff;
      prev_ts_in     = prev_ts_ff;
      longest_iv_in  = longest_iv_ff;
      pend_in        = pend_ff;
      run_v          = run_ff;
      hit_v          = hit_ff;
      iv             = sat_diff32(s1_ts_ff, prev_ts_ff);
      if (s1_valid_ff && advance) begin
         case (s1_kind_ff)
            KIND_START: begin
               if (!mon_ff) begin
                  mon_in   = 1'b1;
                  start_in = s1_ts_ff;
               end
            end
            KIND_STOP: begin
               // a report, if any, is taken from the current state this cycle
               if (mon_ff) begin
                  mon_in         = 1'b0;
                  first_in       = 1'b0;
                  start_in       = '0;
                  frame_in       = '0;
                  miss_in        = '0;
                  run_in         = '0;
                  longest_run_in = '0;
                  hit_in         = '0;
                  have_prev_in   = 1'b0;
                  prev_ts_in     = '0;
                  longest_iv_in  = '0;
                  pend_in        = '0;
               end
            end
            KIND_VSYNC: begin
               if (mon_ff) begin
                  frame_in = sat_inc32(frame_ff);
                  if (first_ff) begin
                     if (pend_ff == '0) begin
                        miss_in = sat_inc32(miss_ff);
                        run_v   = sat_inc32(run_ff);
                        if (hit_ff <= thr_wide) begin
                           hit_in = '0;
                        end
                     end else begin
                        hit_v   = sat_inc32(hit_ff);
                        hit_in  = hit_v;
                        if (hit_v > thr_wide) begin
                           run_v = '0;
                        end
                        pend_in = pend_ff - PEND_WIDTH'(1);
                     end
                     run_in = run_v;
                     if (run_v > longest_run_ff) begin
                        longest_run_in = run_v;
                     end
                  end
               end
            end
            KIND_SWAP: begin
               if (mon_ff) begin
                  first_in = 1'b1;
                  if (pend_ff != '1) begin
                     pend_in = pend_ff + PEND_WIDTH'(1);
                  end
                  have_prev_in = 1'b1;
                  prev_ts_in   = s1_ts_ff;
                  if (have_prev_ff && (iv > longest_iv_ff)) begin
                     longest_iv_in = iv;
                  end
               end
            end
            default: begin
               mon_in = mon_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         mon_ff         <= 1'b0;
         first_ff       <= 1'b0;
         start_ff       <= '0;
         frame_ff       <= '0;
         miss_ff        <= '0;
         run_ff         <= '0;
         longest_run_ff <= '0;
         hit_ff         <= '0;
         have_prev_ff   <= 1'b0;
         prev_ts_ff     <= '0;
         longest_iv_ff  <= '0;
         pend_ff        <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         mon_ff         <= mon_in;
         first_ff       <= first_in;
         start_ff       <= start_in;
         frame_ff       <= frame_in;
         miss_ff        <= miss_in;
         run_ff         <= run_in;
         longest_run_ff <= longest_run_in;
         hit_ff         <= hit_in;
         have_prev_ff   <= have_prev_in;
         prev_ts_ff     <= prev_ts_in;
         longest_iv_ff  <= longest_iv_in;
         pend_ff        <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= s1_kind_in;
      s1_ts_ff   <= s1_ts_in;
   end

`ifndef SYNTHESIS
   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !mon_ff |-> (frame_ff == '0 && miss_ff == '0 && pend_ff == '0 && !first_ff))
      else $error("monitor idle with live counters");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_ff <= longest_run_ff)
      else $error("current miss run above longest run");

   a_miss_after_swap: assert property (@(posedge clock) disable iff (reset)
      (miss_ff != '0) |-> first_ff)
      else $error("missed frame counted before first swap");

   a_stop_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && s1_kind_ff == KIND_STOP) |=> !mon_ff)
      else $error("stop did not disarm monitor");
`endif

endmodule

### hdl/flsm_rsp_reg.sv
// ----------------------------------------------------------------------------
// flsm_rsp_reg
// Result register between the state update and the report channel.
// ----------------------------------------------------------------------------
module flsm_rsp_reg
   import flsm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   output logic            res_ready,
   input  flsm_result_type result,
   flsm_rsp_if.source      rsp
);

   logic            out_valid_ff, out_valid_in;
   flsm_result_type out_data_ff, out_data_in;
   logic            load;

   assign res_ready = !out_valid_ff || rsp.ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.start_time     = out_data_ff.start_time;
   assign rsp.duration       = out_data_ff.duration;
   assign rsp.total_frames   = out_data_ff.total_frames;
   assign rsp.missed_frames  = out_data_ff.missed_frames;
   assign rsp.max_frame_time = out_data_ff.max_frame_time;
   assign rsp.max_missed_run = out_data_ff.max_missed_run;

endmodule

### hdl/frame_loss_statistics_monitor.sv
// ----------------------------------------------------------------------------
// frame_loss_statistics_monitor
// Counts vsyncs, missed frames, miss runs and swap intervals between start
// and stop events, and reports them on stop when any frame was missed.
// ----------------------------------------------------------------------------
// One event item is taken every cycle. An item is registered in the input
// register at its accepting edge and updates the monitor state at the edge on
// which it leaves that register; a report from a stop is loaded into the result
// register at that same edge and is offered on the report channel from the
// following cycle. Event intake pauses only while a report sits in the result
// register with report ready low and a second reporting stop is waiting in the
// input register.
// The loss run threshold sits at byte address 0 of the APB port (reset 1).
module frame_loss_statistics_monitor
   import flsm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   flsm_req_if.sink                  req_ch,
   flsm_rsp_if.source                rsp_ch,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [APB_ADDR_WIDTH-1:0] paddr,
   input  logic [APB_DATA_WIDTH-1:0] pwdata,
   output logic [APB_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [THR_WIDTH-1:0] threshold;
   logic                 res_valid;
   logic                 res_ready;
   flsm_result_type      result;

   flsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold)
   );

   flsm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .threshold (threshold),
      .req       (req_ch),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .result    (result)
   );

   flsm_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .result    (result),
      .rsp       (rsp_ch)
   );

endmodule

### tb/sv/frame_loss_statistics_monitor_tb.sv
// ----------------------------------------------------------------------------
// frame_loss_statistics_monitor_tb
// Drives start, stop, vsync and swap events into the frame loss monitor,
// tracks the monitor state alongside it and checks every loss report it
// emits. The loss run threshold is rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module frame_loss_statistics_monitor_tb
   import flsm_pkg::*;
();

   localparam int CLK_PERIOD    = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 1380;

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [APB_ADDR_WIDTH-1:0] paddr;
   logic [APB_DATA_WIDTH-1:0] pwdata;
   logic [APB_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   flsm_req_if req_bus ();
   flsm_rsp_if rsp_bus ();

   frame_loss_statistics_monitor DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // shadow of the monitor state
   logic                  armed;
   logic                  swap_seen;
   logic                  prev_swap_valid;
   logic [TS_WIDTH-1:0]   arm_stamp;
   logic [TS_WIDTH-1:0]   last_swap_stamp;
   logic [CNT_WIDTH-1:0]  vsync_cnt;
   logic [CNT_WIDTH-1:0]  miss_cnt;
   logic [CNT_WIDTH-1:0]  miss_run;
   logic [CNT_WIDTH-1:0]  worst_run;
   logic [CNT_WIDTH-1:0]  hit_run;
   logic [CNT_WIDTH-1:0]  worst_interval;
   logic [PEND_WIDTH-1:0] buffers_waiting;
   logic [THR_WIDTH-1:0]  threshold;

   flsm_result_type loss_reports_q[$];

   int                  mismatch_count;
   int                  items_sent;
   int                  req_gap_pct;
   int                  rsp_stall_pct;
   logic [TS_WIDTH-1:0] now_ms;

   function automatic logic [CNT_WIDTH-1:0] inc_sat(input logic [CNT_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [CNT_WIDTH-1:0] elapsed_ms(input logic [TS_WIDTH-1:0] later,
                                                       input logic [TS_WIDTH-1:0] earlier);
      logic [TS_WIDTH-1:0] d;
      d = later - earlier;
      if (later <= earlier) return '0;
      if (d[TS_WIDTH-1:CNT_WIDTH] != '0) return '1;
      return d[CNT_WIDTH-1:0];
   endfunction

   task automatic clear_monitor();
      armed           = 1'b0;
      swap_seen       = 1'b0;
      prev_swap_valid = 1'b0;
      arm_stamp       = '0;
      last_swap_stamp = '0;
      vsync_cnt       = '0;
      miss_cnt        = '0;
      miss_run        = '0;
      worst_run       = '0;
      hit_run         = '0;
      worst_interval  = '0;
      buffers_waiting = '0;
   endtask

   task automatic apply_display_event(input flsm_kind_type kind,
                                      input logic [TS_WIDTH-1:0] ts);
      flsm_result_type      rpt;
      logic [CNT_WIDTH-1:0] gap;
      if (kind == KIND_START) begin
         if (!armed) begin
            armed     = 1'b1;
            arm_stamp = ts;
         end
      end else if (armed) begin
         case (kind)
            KIND_STOP: begin
               if (miss_cnt != '0) begin
                  rpt.start_time     = arm_stamp;
                  rpt.duration       = elapsed_ms(ts, arm_stamp);
                  rpt.total_frames   = vsync_cnt;
                  rpt.missed_frames  = miss_cnt;
                  rpt.max_frame_time = worst_interval;
                  rpt.max_missed_run = worst_run;
                  loss_reports_q.push_back(rpt);
               end
               clear_monitor();
            end
            KIND_VSYNC: begin
               vsync_cnt = inc_sat(vsync_cnt);
               if (swap_seen) begin
                  if (buffers_waiting == '0) begin
                     miss_cnt = inc_sat(miss_cnt);
                     miss_run = inc_sat(miss_run);
                     // a long hit streak survives a single miss
                     if (hit_run <= CNT_WIDTH'(threshold)) hit_run = '0;
                  end else begin
                     hit_run = inc_sat(hit_run);
                     if (hit_run > CNT_WIDTH'(threshold)) miss_run = '0;
                     buffers_waiting = buffers_waiting - 1'b1;
                  end
                  if (miss_run > worst_run) worst_run = miss_run;
               end
            end
            default: begin
               swap_seen = 1'b1;
               if (buffers_waiting != '1) buffers_waiting = buffers_waiting + 1'b1;
               if (prev_swap_valid) begin
                  gap = elapsed_ms(ts, last_swap_stamp);
                  if (gap > worst_interval) worst_interval = gap;
               end
               prev_swap_valid = 1'b1;
               last_swap_stamp = ts;
            end
         endcase
      end
   endtask

   // leaves valid high after the accepting edge, so back-to-back items flow
   task automatic send_event(input flsm_kind_type kind, input logic [TS_WIDTH-1:0] ts);
      while (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.timestamp_ms <= ts;
      do @(posedge clock); while (!req_bus.ready);
      apply_display_event(kind, ts);
      items_sent++;
   endtask

   // sender holds off until every report is out and the pipeline is empty
   task automatic settle_monitor();
      req_bus.valid <= 1'b0;
      while (loss_reports_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
      logic [APB_DATA_WIDTH-1:0] word;
      settle_monitor();
      word = $urandom;
      word[THR_WIDTH-1:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= APB_ADDR_WIDTH'(4 * REG_LOSS_RUN_THRESHOLD);
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      threshold = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic logic [THR_WIDTH-1:0] pick_threshold();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1:    return '0;
         2:       return '1;
         3, 4:    return THR_WIDTH'(1);
         5, 6:    return THR_WIDTH'($urandom_range(2, 4));
         default: return THR_WIDTH'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [TS_WIDTH-1:0] random_stamp();
      logic [31:0] lo;
      logic [15:0] hi;
      lo = $urandom;
      hi = 16'($urandom);
      return {hi, lo};
   endfunction

   // mostly small forward steps, with jumps, wild values and time going back
   task automatic advance_clock_ms();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) now_ms = random_stamp();
      else if (r < 8) now_ms = now_ms - TS_WIDTH'($urandom_range(0, 60));
      else if (r < 10) now_ms = now_ms + (TS_WIDTH'($urandom_range(1, 255)) << 32);
      else now_ms = now_ms + TS_WIDTH'($urandom_range(0, 33));
   endtask

   task automatic run_random_session();
      int           len;
      int           swap_pct;
      int           r;
      flsm_kind_type k;
      if ($urandom_range(0, 9) == 0) now_ms = random_stamp();
      advance_clock_ms();
      send_event(KIND_START, now_ms);
      len      = $urandom_range(4, 36);
      swap_pct = $urandom_range(15, 65);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         advance_clock_ms();
         if (r < 4) k = flsm_kind_type'($urandom_range(0, 3));
         else if (r < 4 + swap_pct) k = KIND_SWAP;
         else k = KIND_VSYNC;
         send_event(k, now_ms);
      end
      // now and then the stop is dropped and the next start is ignored
      if ($urandom_range(0, 19) != 0) begin
         advance_clock_ms();
         send_event(KIND_STOP, now_ms);
      end
   endtask

   // events with the monitor disarmed
   task automatic test_idle_events();
      send_event(KIND_STOP, '1);
      send_event(KIND_VSYNC, '0);
      send_event(KIND_SWAP, TS_WIDTH'(48'h5555_AAAA_5555));
   endtask

   task automatic test_report_basics();
      send_event(KIND_START, '0);
      send_event(KIND_START, TS_WIDTH'(5));
      send_event(KIND_VSYNC, '0);
      // first swap at time zero still opens the interval
      send_event(KIND_SWAP, '0);
      send_event(KIND_VSYNC, TS_WIDTH'(1));
      send_event(KIND_VSYNC, TS_WIDTH'(2));
      send_event(KIND_VSYNC, TS_WIDTH'(3));
      send_event(KIND_SWAP, TS_WIDTH'(20));
      send_event(KIND_SWAP, TS_WIDTH'(10));
      send_event(KIND_SWAP, TS_WIDTH'(48'h0100_0000_0000));
      send_event(KIND_STOP, '1);
   endtask

   task automatic test_time_backwards();
      send_event(KIND_START, '1);
      send_event(KIND_SWAP, TS_WIDTH'(48'hAAAA_5555_AAAA));
      send_event(KIND_VSYNC, '0);
      send_event(KIND_VSYNC, '0);
      send_event(KIND_STOP, TS_WIDTH'(5));
   endtask

   task automatic test_clean_stop();
      send_event(KIND_START, TS_WIDTH'(100));
      send_event(KIND_SWAP, TS_WIDTH'(110));
      send_event(KIND_VSYNC, TS_WIDTH'(120));
      send_event(KIND_STOP, TS_WIDTH'(130));
   endtask

   task automatic test_threshold_extremes();
      write_threshold('0);
      repeat (3) run_random_session();
      write_threshold('1);
      repeat (3) run_random_session();
   endtask

   task automatic test_random_traffic();
      int goal;
      for (int mode = 0; mode < 3; mode++) begin
         req_gap_pct   = (mode == 0) ? 21 : (mode == 1) ? 58 : 0;
         rsp_stall_pct = (mode == 0) ? 58 : (mode == 1) ? 21 : 0;
         goal = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < goal) begin
            if ($urandom_range(0, 4) == 0) write_threshold(pick_threshold());
            run_random_session();
         end
      end
   endtask

   // report checker and result-side backpressure
   always @(posedge clock) begin
      flsm_result_type want;
      flsm_result_type got;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.start_time     = rsp_bus.start_time;
            got.duration       = rsp_bus.duration;
            got.total_frames   = rsp_bus.total_frames;
            got.missed_frames  = rsp_bus.missed_frames;
            got.max_frame_time = rsp_bus.max_frame_time;
            got.max_missed_run = rsp_bus.max_missed_run;
            if (loss_reports_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected report: start %h dur %0d frames %0d missed %0d",
                           got.start_time, got.duration, got.total_frames,
                           got.missed_frames);
            end else begin
               want = loss_reports_q.pop_front();
               if (got.start_time !== want.start_time || got.duration !== want.duration ||
                   got.total_frames !== want.total_frames ||
                   got.missed_frames !== want.missed_frames ||
                   got.max_frame_time !== want.max_frame_time ||
                   got.max_missed_run !== want.max_missed_run) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("report mismatch at %0t", $time);
                     $display("  expected start %h dur %0d frames %0d missed %0d ft %0d run %0d",
                              want.start_time, want.duration, want.total_frames,
                              want.missed_frames, want.max_frame_time, want.max_missed_run);
                     $display("  actual   start %h dur %0d frames %0d missed %0d ft %0d run %0d",
                              got.start_time, got.duration, got.total_frames,
                              got.missed_frames, got.max_frame_time, got.max_missed_run);
                  end
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   initial begin
      #(CLK_PERIOD * 400000);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.kind         = KIND_START;
      req_bus.timestamp_ms = '0;
      rsp_bus.ready        = 1'b0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      mismatch_count       = 0;
      items_sent           = 0;
      req_gap_pct          = 21;
      rsp_stall_pct        = 58;
      now_ms               = '0;
      clear_monitor();
      threshold = THR_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_events();
      test_report_basics();
      test_time_backwards();
      test_clean_stop();
      test_threshold_extremes();
      test_random_traffic();

      settle_monitor();
      if (mismatch_count == 0 && loss_reports_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
